// ===== rtl/bbc_pkg.sv =====
// Shared types, character codes and sizes for the bracket balance checker.
`default_nettype none

package bbc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LSQ    = 8'h5B;
    localparam logic [7:0] CH_RSQ    = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [1:0] {
        KIND_PAREN  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_BRACE  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        OP_SKIP  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2
    } t_op_class;

    typedef enum logic [1:0] {
        VERDICT_OK       = 2'd0,
        VERDICT_MISMATCH = 2'd1,
        VERDICT_UNCLOSED = 2'd2,
        VERDICT_OVERFLOW = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_beat;

    typedef struct packed {
        t_verdict verdict_code;
        logic     is_balanced;
    } t_out_beat;

    // classified byte as carried between front and back
    typedef struct packed {
        t_op_class op_class;
        t_kind     kind;
        logic      last;
    } t_op;

endpackage

`default_nettype wire

// ===== rtl/bbc_front.sv =====
// Front end: classifies each text byte into open, close or skip with its bracket kind.
`default_nettype none

module bbc_front
    import bbc_pkg::*;
(
    input  wire t_in_beat i_in,
    output t_op           o_op
);

    always_comb begin
        o_op.last     = i_in.end_of_text;
        o_op.op_class = OP_SKIP;
        o_op.kind     = KIND_PAREN;
        case (i_in.text_byte)
            CH_LPAREN: begin
                o_op.op_class = OP_OPEN;
                o_op.kind     = KIND_PAREN;
            end
            CH_LSQ: begin
                o_op.op_class = OP_OPEN;
                o_op.kind     = KIND_SQUARE;
            end
            CH_LBRACE: begin
                o_op.op_class = OP_OPEN;
                o_op.kind     = KIND_BRACE;
            end
            CH_RPAREN: begin
                o_op.op_class = OP_CLOSE;
                o_op.kind     = KIND_PAREN;
            end
            CH_RSQ: begin
                o_op.op_class = OP_CLOSE;
                o_op.kind     = KIND_SQUARE;
            end
            CH_RBRACE: begin
                o_op.op_class = OP_CLOSE;
                o_op.kind     = KIND_BRACE;
            end
            default: begin
                o_op.op_class = OP_SKIP;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/bbc_queue.sv =====
// Short queue of classified bytes between front and back.
`default_nettype none

module bbc_queue
    import bbc_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_wr,
    input  wire t_op i_op,
    output logic     o_full,
    input  wire      i_rd,
    output logic     o_valid,
    output t_op      o_op
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

    t_op              r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [QC_W-1:0]  r_cnt, n_cnt;

    assign o_full  = (r_cnt == QC_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_slot[r_rp];

    always_comb begin
        n_wp = r_wp;
        if (i_wr) begin
            n_wp = (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(r_wp + 1'b1);
        end
        n_rp = r_rp;
        if (i_rd) begin
            n_rp = (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(r_rp + 1'b1);
        end
        n_cnt = r_cnt;
        if (i_wr && !i_rd) begin
            n_cnt = QC_W'(r_cnt + 1'b1);
        end else if (i_rd && !i_wr) begin
            n_cnt = QC_W'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wp] <= i_op;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bbc_back.sv =====
// Back end: opener stack, failure latch, verdict and two-deep result buffer.
`default_nettype none

module bbc_back
    import bbc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_q_valid,
    input  wire t_op   i_op,
    output logic       o_q_rd,
    input  wire        i_pop,
    output logic       o_empty,
    output t_out_beat  o_result
);

    // stack storage; top two entries mirrored in registers
    t_kind            r_mem [STACK_DEPTH];
    t_kind            r_top;
    t_kind            r_below;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_failed, n_failed;
    t_verdict         r_fail_kind, n_fail_kind;

    t_out_beat        r_ob [2];
    logic             r_owp, r_orp;
    logic [1:0]       r_ocnt, n_ocnt;

    logic             go, live, do_push, do_pop, ovf, bad_close, out_full, out_rd;
    logic [CNT_W-1:0] cnt_after, rd_tmp;
    logic [IDX_W-1:0] rd_idx;
    t_verdict         verdict;
    logic             fail_now;
    t_verdict         kind_now;

    assign out_full = (r_ocnt == 2'd2);
    assign go       = i_q_valid && !out_full;
    assign o_q_rd   = go;
    assign live     = go && !r_failed;

    assign do_push   = live && (i_op.op_class == OP_OPEN) && (r_count != CNT_W'(STACK_DEPTH));
    assign ovf       = live && (i_op.op_class == OP_OPEN) && (r_count == CNT_W'(STACK_DEPTH));
    assign do_pop    = live && (i_op.op_class == OP_CLOSE) && (r_count != '0)
                       && (r_top == i_op.kind);
    assign bad_close = live && (i_op.op_class == OP_CLOSE)
                       && ((r_count == '0) || (r_top != i_op.kind));

    assign rd_tmp = r_count - CNT_W'(3);
    assign rd_idx = rd_tmp[IDX_W-1:0];

    always_comb begin
        cnt_after = r_count;
        if (do_push) begin
            cnt_after = CNT_W'(r_count + 1'b1);
        end else if (do_pop) begin
            cnt_after = CNT_W'(r_count - 1'b1);
        end

        fail_now = r_failed || ovf || bad_close;
        if (r_failed) begin
            kind_now = r_fail_kind;
        end else if (ovf) begin
            kind_now = VERDICT_OVERFLOW;
        end else begin
            kind_now = VERDICT_MISMATCH;
        end

        if (fail_now) begin
            verdict = kind_now;
        end else if (cnt_after != '0) begin
            verdict = VERDICT_UNCLOSED;
        end else begin
            verdict = VERDICT_OK;
        end

        n_count     = cnt_after;
        n_failed    = fail_now;
        n_fail_kind = fail_now ? kind_now : VERDICT_OK;
        if (go && i_op.last) begin
            n_count     = '0;
            n_failed    = 1'b0;
            n_fail_kind = VERDICT_OK;
        end else if (!go) begin
            n_failed    = r_failed;
            n_fail_kind = r_fail_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_failed    <= 1'b0;
            r_fail_kind <= VERDICT_OK;
        end else begin
            r_count     <= n_count;
            r_failed    <= n_failed;
            r_fail_kind <= n_fail_kind;
        end
    end

    // stack memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_count[IDX_W-1:0]] <= i_op.kind;
            r_top                     <= i_op.kind;
            r_below                   <= r_top;
        end else if (do_pop) begin
            r_top   <= r_below;
            r_below <= r_mem[rd_idx];
        end
    end

    // result buffer
    assign out_rd   = i_pop && (r_ocnt != 2'd0);
    assign o_empty  = (r_ocnt == 2'd0);
    assign o_result = r_ob[r_orp];

    always_comb begin
        n_ocnt = r_ocnt;
        if ((go && i_op.last) && !out_rd) begin
            n_ocnt = r_ocnt + 2'd1;
        end else if (out_rd && !(go && i_op.last)) begin
            n_ocnt = r_ocnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (go && i_op.last) begin
                r_owp <= ~r_owp;
            end
            if (out_rd) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= n_ocnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && i_op.last) begin
            r_ob[r_owp].verdict_code <= verdict;
            r_ob[r_owp].is_balanced  <= (verdict == VERDICT_OK);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bracket_balance_checker.sv =====
// Top level of the bracket balance checker: front, byte queue and stack engine.
`default_nettype none

// Checks texts streamed one byte per beat for properly nested (), [] and {}.
// Input and result sides both behave as queues: a beat goes in when push is
// high and full is low, and a verdict is taken when pop is high and empty is
// low. One byte is accepted every cycle while full is low; the stack engine
// retires one byte per cycle while the verdict buffer has room, with the top
// two openers held in registers, so a pop needs only the single registered
// read port of the 64-entry stack memory. A verdict is produced only for the
// byte flagged end_of_text and is buffered when the engine retires that byte.
// A four-deep byte queue sits between classifier and stack engine, and a
// two-deep verdict buffer at the output; full rises only once both have filled
// behind a stalled consumer. Verdict codes: 0 balanced, 1 mismatch or stray
// closer, 2 unclosed openers, 3 stack overflow. After a failure the rest of
// that text is ignored, and all per-text state clears after the final byte.
module bracket_balance_checker
    import bbc_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            push,
    output logic           full,
    input  wire t_in_beat  i_item,
    output logic           empty,
    input  wire            pop,
    output t_out_beat      o_result
);

    t_op  fe_op;
    t_op  q_op;
    logic q_wr;
    logic q_full;
    logic q_valid;
    logic q_rd;

    // classify the incoming byte
    bbc_front u_front (
        .i_in (i_item),
        .o_op (fe_op)
    );

    assign full = q_full;
    assign q_wr = push && !q_full;

    // decoupling queue between classifier and stack engine
    bbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_op    (fe_op),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    // stack engine and verdict buffer
    bbc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_op      (q_op),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

`ifndef SYNTHESIS
    // engine never draws from an empty byte queue
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_rd |-> q_valid)
        else $error("byte queue read while empty");

    // a byte without the end flag never creates or removes a verdict
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(q_rd && q_op.last) && !(pop && !empty)) |=> $stable(empty))
        else $error("verdict buffer changed without a final byte or a pop");

    // reset leaves both queues empty
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // balanced flag agrees with the verdict code
    a_flag_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.is_balanced == (o_result.verdict_code == VERDICT_OK)))
        else $error("is_balanced disagrees with verdict_code");
`endif

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the bracket balance checker: stimulus, prediction and scoreboard.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bbc_pkg::*;

    localparam int TARGET_BEATS = 1050;    // input beats to send
    localparam int CYCLE_LIMIT  = 200000;  // timeout, far beyond the slowest legal run
    localparam int CALM_START   = 1500;    // window with no idling on either side
    localparam int CALM_END     = 2500;
    localparam int STALL_AFTER  = 40;      // verdicts seen before the long consumer hold-off
    localparam int STALL_CYCLES = 400;
    localparam int TAIL_CYCLES  = 10;

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_beat  tx_beat = '0;
    logic      full;
    logic      empty;
    t_out_beat rx_beat;

    always #5 i_clk = ~i_clk;

    bracket_balance_checker dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (tx_beat),
        .empty    (empty),
        .pop      (pop),
        .o_result (rx_beat)
    );

    // ------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------
    t_in_beat   pending_q[$];    // beats still to be offered, oldest first
    t_out_beat  verdict_q[$];    // verdicts predicted but not yet seen
    int         drain_pts[$];    // beat counts at which the sender waits for all verdicts
    logic [7:0] text_buf[$];     // text being built by the generator

    int cyc          = 0;
    int accepted     = 0;
    int results_seen = 0;
    int errors       = 0;
    int texts        = 0;
    int beats_built  = 0;
    int verdict_hits[4] = '{0, 0, 0, 0};

    // hold-off of the consumer, counted down in its own process
    int hold_left  = 0;
    bit stall_done = 1'b0;

    // ------------------------------------------------------------------
    // Predictor: own copy of the opener stack and per-text failure state
    // ------------------------------------------------------------------
    t_kind    nest_stack[STACK_DEPTH];
    int       nest_depth  = 0;
    bit       text_failed = 1'b0;
    t_verdict fail_code   = VERDICT_OK;

    task automatic bracket_predict(input t_in_beat b);
        t_kind     k;
        bit        is_br;
        bit        is_open;
        t_out_beat v;
        is_br   = 1'b1;
        is_open = 1'b0;
        k       = KIND_PAREN;
        case (b.text_byte)
            CH_LPAREN: begin k = KIND_PAREN;  is_open = 1'b1; end
            CH_LSQ:    begin k = KIND_SQUARE; is_open = 1'b1; end
            CH_LBRACE: begin k = KIND_BRACE;  is_open = 1'b1; end
            CH_RPAREN: k = KIND_PAREN;
            CH_RSQ:    k = KIND_SQUARE;
            CH_RBRACE: k = KIND_BRACE;
            default:   is_br = 1'b0;
        endcase

        // once a text has failed, everything up to its end is ignored
        if (!text_failed && is_br) begin
            if (is_open) begin
                if (nest_depth >= STACK_DEPTH) begin
                    text_failed = 1'b1;
                    fail_code   = VERDICT_OVERFLOW;
                end else begin
                    nest_stack[nest_depth] = k;
                    nest_depth++;
                end
            end else if (nest_depth == 0 || nest_stack[nest_depth-1] != k) begin
                // stray closer on an empty stack, or wrong kind on top
                text_failed = 1'b1;
                fail_code   = VERDICT_MISMATCH;
            end else begin
                nest_depth--;
            end
        end

        // the final byte is processed first, then the verdict is formed
        if (b.end_of_text) begin
            if (text_failed)
                v.verdict_code = fail_code;
            else if (nest_depth != 0)
                v.verdict_code = VERDICT_UNCLOSED;
            else
                v.verdict_code = VERDICT_OK;
            v.is_balanced = (v.verdict_code == VERDICT_OK);
            verdict_q.push_back(v);
            nest_depth  = 0;
            text_failed = 1'b0;
            fail_code   = VERDICT_OK;
        end
    endtask

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Text generation helpers
    // ------------------------------------------------------------------
    function automatic bit is_bracket(input logic [7:0] c);
        return c == CH_LPAREN || c == CH_RPAREN || c == CH_LSQ ||
               c == CH_RSQ    || c == CH_LBRACE || c == CH_RBRACE;
    endfunction

    function automatic logic [7:0] opener_of(input t_kind k);
        case (k)
            KIND_SQUARE: return CH_LSQ;
            KIND_BRACE:  return CH_LBRACE;
            default:     return CH_LPAREN;
        endcase
    endfunction

    function automatic logic [7:0] closer_of(input t_kind k);
        case (k)
            KIND_SQUARE: return CH_RSQ;
            KIND_BRACE:  return CH_RBRACE;
            default:     return CH_RPAREN;
        endcase
    endfunction

    function automatic logic [7:0] any_bracket();
        t_kind k;
        k = t_kind'($urandom_range(0, 2));
        return $urandom_range(0, 1) ? opener_of(k) : closer_of(k);
    endfunction

    // filler byte that is never a bracket
    function automatic logic [7:0] noise_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        return is_bracket(c) ? 8'h61 : c;
    endfunction

    task automatic put_text(input string s);
        foreach (s[i]) text_buf.push_back(s[i]);
    endtask

    // turn the text buffer into beats, end-of-text on the last byte
    task automatic seal();
        t_in_beat b;
        if (text_buf.size() == 0)
            text_buf.push_back(noise_byte());
        foreach (text_buf[i]) begin
            b.text_byte   = text_buf[i];
            b.end_of_text = (i == text_buf.size() - 1);
            pending_q.push_back(b);
            beats_built++;
        end
        text_buf.delete();
        texts++;
    endtask

    // properly nested run with filler; optionally left open or damaged at one spot
    task automatic nested_text(input int len, input int max_d, input bit close_all,
                               input bit corrupt);
        t_kind open_kinds[$];
        t_kind k;
        int    pos;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                text_buf.push_back(noise_byte());
            end else if (open_kinds.size() == 0 ||
                         (open_kinds.size() < max_d && $urandom_range(0, 1) == 1)) begin
                k = t_kind'($urandom_range(0, 2));
                open_kinds.push_back(k);
                text_buf.push_back(opener_of(k));
            end else begin
                text_buf.push_back(closer_of(open_kinds.pop_back()));
            end
        end
        if (close_all)
            while (open_kinds.size() != 0)
                text_buf.push_back(closer_of(open_kinds.pop_back()));
        if (corrupt && text_buf.size() != 0) begin
            pos = $urandom_range(0, text_buf.size() - 1);
            text_buf[pos] = any_bracket();
        end
    endtask

    function automatic bit take_break();
        if (cyc >= CALM_START && cyc < CALM_END)
            return 1'b0;
        return $urandom_range(0, 99) < 33;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers the oldest pending beat on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_in
        bit offer;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            offer = (pending_q.size() != 0);
            // planned pause: nothing more until every verdict so far is back
            if (drain_pts.size() != 0 && accepted == drain_pts[0]) begin
                if (verdict_q.size() == 0)
                    drain_pts.pop_front();
                offer = 1'b0;
            end
            if (take_break())
                offer = 1'b0;
            push <= offer;
            if (offer)
                tx_beat <= pending_q[0];
        end
    end

    // consumer: random pop, forced low during the long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n)
            pop <= 1'b0;
        else
            pop <= (hold_left == 0) && !take_break();
    end

    // long hold-off so the byte queue and verdict buffer fill and full rises
    always @(negedge i_clk) begin
        if (!stall_done && results_seen >= STALL_AFTER) begin
            hold_left  <= STALL_CYCLES;
            stall_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: both handshakes sampled on the rising edge.
    // Verdicts are checked before the input beat of the same edge is
    // predicted; a verdict can never belong to a beat taken that edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_out_beat exp_v;
        if (i_rst_n) begin
            if (pop && !empty) begin
                results_seen++;
                if (verdict_q.size() == 0) begin
                    report($sformatf("verdict %0d with none expected", rx_beat.verdict_code));
                end else begin
                    exp_v = verdict_q.pop_front();
                    verdict_hits[exp_v.verdict_code]++;
                    if (rx_beat.verdict_code !== exp_v.verdict_code)
                        report($sformatf("verdict_code %0d, expected %0d",
                                         rx_beat.verdict_code, exp_v.verdict_code));
                    if (rx_beat.is_balanced !== exp_v.is_balanced)
                        report($sformatf("is_balanced %0b, expected %0b",
                                         rx_beat.is_balanced, exp_v.is_balanced));
                end
            end
            if (push && !full) begin
                bracket_predict(tx_beat);
                void'(pending_q.pop_front());
                accepted++;
            end
        end
    end

    // cycle count and timeout
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        int    pick;
        int    n_open;
        bit    mid_drain;
        t_kind deep_kinds[$];
        t_kind k;

        mid_drain = 1'b0;

        // directed texts
        put_text("a");      seal();   // no brackets at all
        put_text("()");     seal();
        put_text("[]");     seal();
        put_text("{}");     seal();
        put_text("({[]})"); seal();
        put_text(")");      seal();   // stray closer on an empty stack, failing on the last byte
        put_text("(]");     seal();   // wrong kind on top
        put_text("[");                // opener left behind, top byte value
        text_buf.push_back(8'hFF);
        seal();
        put_text(")(");               // later bytes ignored after a failure, zero byte value
        text_buf.push_back(8'h00);
        seal();
        put_text("{)}");    seal();   // mismatch in the middle, rest ignored

        // stack exactly full then unwound, and one opener too many
        for (int d = STACK_DEPTH; d <= STACK_DEPTH + 1; d++) begin
            for (int i = 0; i < d; i++) begin
                k = t_kind'($urandom_range(0, 2));
                deep_kinds.push_back(k);
                text_buf.push_back(opener_of(k));
            end
            while (deep_kinds.size() != 0)
                text_buf.push_back(closer_of(deep_kinds.pop_back()));
            seal();
        end
        drain_pts.push_back(pending_q.size());

        // random texts, mostly well nested so deep stacks are reached
        while (beats_built < TARGET_BEATS) begin
            if (beats_built >= TARGET_BEATS / 2 && !mid_drain) begin
                drain_pts.push_back(pending_q.size());
                mid_drain = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                nested_text($urandom_range(1, 16), $urandom_range(1, 8),
                            $urandom_range(0, 4) != 0, $urandom_range(0, 5) == 0);
            end else if (pick < 82) begin
                repeat ($urandom_range(1, 10))
                    text_buf.push_back($urandom_range(0, 1) ? any_bracket() : noise_byte());
            end else if (pick < 84) begin
                // around the stack limit, closed or left open
                n_open = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 3);
                for (int i = 0; i < n_open; i++) begin
                    k = t_kind'($urandom_range(0, 2));
                    deep_kinds.push_back(k);
                    text_buf.push_back(opener_of(k));
                end
                if ($urandom_range(0, 3) != 0)
                    while (deep_kinds.size() != 0)
                        text_buf.push_back(closer_of(deep_kinds.pop_back()));
                deep_kinds.delete();
            end else begin
                // raw bytes over the full range
                repeat ($urandom_range(1, 8))
                    text_buf.push_back(8'($urandom_range(0, 255)));
            end
            seal();
        end

        // release reset on a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d texts in %0d beats, %0d verdicts checked, %0d cycles",
                 texts, accepted, results_seen, cyc);
        $display("verdicts: balanced %0d, mismatch %0d, unclosed %0d, overflow %0d",
                 verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3]);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
